@@ hw/rtl/ppsch_pkg.sv @@
// Shared types and constants for the preemptive priority scheduler.
// No dependencies; imported by ppsch_cell and the core top level.
`default_nettype none

package ppsch_pkg;

  localparam int TIME_W     = 16;
  localparam int PRIO_W     = 8;
  localparam int SLOT_W     = 4;
  localparam int OP_W       = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 88;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  // Busy-slot count saturating at two: enough to decide all_done.
  localparam logic [1:0] BUSY_NONE = 2'd0;
  localparam logic [1:0] BUSY_ONE  = 2'd1;
  localparam logic [1:0] BUSY_MANY = 2'd2;

  // Best-so-far candidate handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] remaining;
    logic [1:0]        busy;
  } token_t;

  // Broadcast command from the sequencer to every cell.
  typedef struct packed {
    logic              clear;
    logic              load;
    logic [SLOT_W-1:0] load_slot;
    logic [TIME_W-1:0] load_arrival;
    logic [TIME_W-1:0] load_burst;
    logic [PRIO_W-1:0] load_prio;
    logic              dec;
    logic [TIME_W-1:0] time_now;
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/ppsch_cell.sv @@
// One task slot of the scheduler chain plus its stage of the min-priority scan.
// Depends on ppsch_pkg (token_t, cell_cmd_t).
`default_nettype none

module ppsch_cell #(
  parameter int IDX = 0,
  parameter int SW  = 4
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire ppsch_pkg::cell_cmd_t cmd_i,
  input  wire [SW-1:0]              dec_slot_i,
  input  wire ppsch_pkg::token_t    tok_i,
  input  wire [SW-1:0]              tok_slot_i,
  output ppsch_pkg::token_t         tok_o,
  output logic [SW-1:0]             tok_slot_o
);
  import ppsch_pkg::*;

  localparam int IW = (SW > SLOT_W) ? SW : SLOT_W;

  logic              loaded_q, loaded_d;
  logic [TIME_W-1:0] arr_q, arr_d;
  logic [TIME_W-1:0] burst_q, burst_d;
  logic [TIME_W-1:0] rem_q, rem_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  token_t            tok_q, tok_d;
  logic [SW-1:0]     slot_q, slot_d;

  logic busy, ready, better, load_hit, dec_hit;

  assign load_hit = cmd_i.load && (IW'(cmd_i.load_slot) == IW'(IDX));
  assign dec_hit  = cmd_i.dec && (dec_slot_i == SW'(IDX));

  assign busy  = loaded_q && (rem_q != '0);
  assign ready = busy && (arr_q <= cmd_i.time_now);
  // Strict compare keeps the earlier slot on a full tie.
  assign better = ready && (!tok_i.valid || (prio_q < tok_i.prio) ||
                  ((prio_q == tok_i.prio) && (arr_q < tok_i.arrival)));

  always_comb begin
    loaded_d = loaded_q;
    arr_d    = arr_q;
    burst_d  = burst_q;
    rem_d    = rem_q;
    prio_d   = prio_q;
    if (cmd_i.clear) begin
      loaded_d = 1'b0;
    end else if (load_hit) begin
      loaded_d = 1'b1;
      arr_d    = cmd_i.load_arrival;
      burst_d  = cmd_i.load_burst;
      rem_d    = cmd_i.load_burst;
      prio_d   = cmd_i.load_prio;
    end else if (dec_hit) begin
      rem_d = rem_q - TIME_W'(1);
    end
  end

  always_comb begin
    tok_d  = tok_i;
    slot_d = tok_slot_i;
    if (better) begin
      tok_d.valid     = 1'b1;
      tok_d.prio      = prio_q;
      tok_d.arrival   = arr_q;
      tok_d.burst     = burst_q;
      tok_d.remaining = rem_q;
      slot_d          = SW'(IDX);
    end
    if (busy) begin
      tok_d.busy = (tok_i.busy == BUSY_NONE) ? BUSY_ONE : BUSY_MANY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
      tok_q    <= '0;
      slot_q   <= '0;
    end else begin
      loaded_q <= loaded_d;
      tok_q    <= tok_d;
      slot_q   <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    arr_q   <= arr_d;
    burst_q <= burst_d;
    rem_q   <= rem_d;
    prio_q  <= prio_d;
  end

  assign tok_o      = tok_q;
  assign tok_slot_o = slot_q;

endmodule

`default_nettype wire

@@ hw/rtl/preemptive_priority_scheduler_core.sv @@
// Preemptive priority scheduler: a chain of MAX_TASKS slot cells with a scan token.
// Load and clear are taken in idle. Tick: a scan through every cell, then an update
// that registers the result; new items are taken only in idle, and the update
// stalls while the previous result waits on m_axis_tready.
// Reset (async, active low) empties every slot, zeroes time and start_time.
// Depends on ppsch_pkg and ppsch_cell.
`default_nettype none

module preemptive_priority_scheduler_core #(
  parameter int MAX_TASKS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration: start_time[15:0]
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [15:0] cfg_data_i,
  // input stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // slot[3:0], arrival_time[19:4], burst[35:20], priority_req[43:36], zero[47:44]
  input  wire  [ppsch_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // op[1:0]
  input  wire  [ppsch_pkg::OP_W-1:0]      s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // run_slot[3:0], remaining[19:4], completed[20], finish_time[36:21],
  // turnaround[52:37], waiting[68:53], all_done[69], time_now[85:70], zero[87:86]
  output logic [ppsch_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // run_valid[0]
  output logic        m_axis_tuser
);
  import ppsch_pkg::*;

  localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = SW;

  // ---------------------------------------------------------------------------
  // Sequencer and shared registers
  // ---------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic [TIME_W-1:0] start_time_q;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              out_run_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [TIME_W-1:0] out_rem_q;
  logic              out_comp_q;
  logic [TIME_W-1:0] out_fin_q;
  logic [TIME_W-1:0] out_tat_q;
  logic [TIME_W-1:0] out_wait_q;
  logic              out_done_q;
  logic [TIME_W-1:0] out_time_q;
  logic              out_load;

  cell_cmd_t         cmd;
  logic              in_xfer;
  op_e               op;

  // chain taps: index k is the token entering cell k
  token_t            tok   [MAX_TASKS+1];
  logic [SW-1:0]     tslot [MAX_TASKS+1];
  token_t            best;
  logic [SW-1:0]     best_slot;

  logic [TIME_W-1:0] time_next, rem_next, tat, wait_v;
  logic              done_next;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign op            = op_e'(s_axis_tuser);

  assign best      = tok[MAX_TASKS];
  assign best_slot = tslot[MAX_TASKS];

  assign time_next = (time_q == '1) ? time_q : time_q + TIME_W'(1);
  assign rem_next  = best.remaining - TIME_W'(1);
  // Picked task has arrival <= time, so this never wraps.
  assign tat       = time_next - best.arrival;
  assign wait_v    = (tat >= best.burst) ? tat - best.burst : '0;
  assign done_next = (best.busy == BUSY_NONE) ||
                     ((best.busy == BUSY_ONE) && best.valid &&
                      (best.remaining == TIME_W'(1)));

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    time_d   = time_q;
    out_load = 1'b0;

    cmd              = '0;
    cmd.load_slot    = s_axis_tdata[3:0];
    cmd.load_arrival = s_axis_tdata[19:4];
    cmd.load_burst   = s_axis_tdata[35:20];
    cmd.load_prio    = s_axis_tdata[43:36];
    cmd.time_now     = time_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (op)
            OP_LOAD:  cmd.load = 1'b1;
            OP_CLEAR: begin
              cmd.clear = 1'b1;
              time_d    = start_time_q;
            end
            OP_TICK: begin
              state_d = ST_SCAN;
              cnt_d   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // token must pass through every cell before it leaves the last one
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(MAX_TASKS - 1)) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          cmd.dec  = best.valid;
          time_d   = time_next;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      time_q       <= '0;
      start_time_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      time_q      <= time_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        start_time_q <= cfg_data_i;
      end
    end
  end

  // Result payload; finish, turnaround and wait are zero unless the run completes.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_run_q  <= best.valid;
      out_slot_q <= best.valid ? SLOT_W'(best_slot) : '0;
      out_rem_q  <= best.valid ? rem_next : '0;
      out_comp_q <= best.valid && (rem_next == '0);
      out_fin_q  <= (best.valid && (rem_next == '0)) ? time_next : '0;
      out_tat_q  <= (best.valid && (rem_next == '0)) ? tat : '0;
      out_wait_q <= (best.valid && (rem_next == '0)) ? wait_v : '0;
      out_done_q <= done_next;
      out_time_q <= time_next;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_run_q;
  assign m_axis_tdata  = {2'b00, out_time_q, out_done_q, out_wait_q, out_tat_q,
                          out_fin_q, out_comp_q, out_rem_q, out_slot_q};

  // ---------------------------------------------------------------------------
  // Cell chain: the head sees an empty candidate every cycle.
  // ---------------------------------------------------------------------------
  assign tok[0]   = '0;
  assign tslot[0] = '0;

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    ppsch_cell #(
      .IDX (g),
      .SW  (SW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .dec_slot_i (best_slot),
      .tok_i      (tok[g]),
      .tok_slot_i (tslot[g]),
      .tok_o      (tok[g+1]),
      .tok_slot_o (tslot[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_result_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_UPDATE))
    else $error("result raised outside the update step");

  a_pick_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) && best.valid |-> best.remaining != '0)
    else $error("scan picked a slot with no work left");

  a_completed_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_comp_q |-> out_run_q && (out_rem_q == '0))
    else $error("completion reported without a finished run");

  a_scan_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q <= CW'(MAX_TASKS - 1)))
    else $error("scan counter past the last cell");

endmodule

`default_nettype wire
